// ----- rtl/core/sorted_unique_key_list_assert.svh -----
// Assertion macros for the sorted unique key list.
`ifndef SORTED_UNIQUE_KEY_LIST_ASSERT_SVH
`define SORTED_UNIQUE_KEY_LIST_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define SUKL_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent at one edge requires the consequent at the following edge.
`define SUKL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sukl_pkg.sv -----
// Package: sizes, codes and word types of the sorted unique key list.
`timescale 1ns / 1ps

package sukl_pkg;

	// number of cells in the chain
	localparam int CAPACITY = 16;
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// request modes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_DUMP   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND  = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_ENTRY     = 3'd6;

	// input word
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] key;
	} req_t;

	// result word
	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value;
		logic               last;
	} rsp_t;

	// per-cycle action broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] key;
	} cell_ctl_t;

endpackage

// ----- rtl/core/sorted_unique_key_list.sv -----
// Top level: sorted list of unique signed keys kept in a chain of compare cells.
//
//   channel   direction  handshake                    word
//   request   in         start, accepted when !busy   req (mode, key)
//   result    out        strobe, one cycle, no stall  rsp (status, value, last)
//
// Insert and remove results appear the cycle after accept and the next word may be
// accepted right then. A dump of a non-empty list holds busy while it gives one
// result a cycle, one per entry, rotating the chain once round; a dump of an empty
// list gives a single ST_EMPTY result. Reset clears the occupancy count, dump state
// and strobe; cell keys are left as they are. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "sorted_unique_key_list_assert.svh"

module sorted_unique_key_list
	import sukl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output rsp_t rsp
);

	logic [OCC_W-1:0]   occ_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               dump_q;
	logic               strobe_q;
	rsp_t               rsp_q;

	cell_ctl_t          ctl;
	logic signed [31:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_eq;
	logic [CAPACITY-2:0] order_ok;

	logic accept;
	logic found;
	logic full;
	logic empty;
	logic dump_last;
	logic single_op;

	assign busy   = dump_q;
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	assign accept    = start && !busy;
	assign found     = |cell_eq;
	assign full      = (occ_q == OCC_W'(CAPACITY));
	assign empty     = (occ_q == '0);
	assign dump_last = ((OCC_W'(cnt_q) + OCC_W'(1)) == occ_q);

	// accepted word that gives exactly one result
	assign single_op = accept && (req.mode == MODE_INSERT || req.mode == MODE_REMOVE);

	// occupied cells form a prefix of the chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_valid
		assign cell_valid[i] = (occ_q > OCC_W'(i));
	end

	// action for the chain this cycle
	always_comb begin
		ctl.key = req.key;
		ctl.op  = CELL_HOLD;
		if (dump_q) begin
			ctl.op = CELL_ROTATE;
		end else if (accept && req.mode == MODE_INSERT && !found && !full) begin
			ctl.op = CELL_INSERT;
		end else if (accept && req.mode == MODE_REMOVE && found) begin
			ctl.op = CELL_REMOVE;
		end
	end

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev_key;
		logic               prev_lt;
		logic signed [31:0] next_key;
		logic               next_valid;

		if (i == 0) begin : g_head
			assign prev_key = cell_key[i];
			assign prev_lt  = 1'b1;
		end else begin : g_body
			assign prev_key = cell_key[i-1];
			assign prev_lt  = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_key   = cell_key[i];
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_key   = cell_key[i+1];
			assign next_valid = cell_valid[i+1];
		end

		sukl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (cell_valid[i]),
			.prev_key   (prev_key),
			.prev_lt    (prev_lt),
			.next_key   (next_key),
			.next_valid (next_valid),
			.head_key   (cell_key[0]),
			.key        (cell_key[i]),
			.lt         (cell_lt[i]),
			.eq         (cell_eq[i])
		);
	end

	// strict ascending order of neighboring occupied cells
	for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_order
		assign order_ok[i] = !cell_valid[i+1] || (cell_key[i] < cell_key[i+1]);
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (dump_q) begin
			rsp_q.status <= ST_ENTRY;
			rsp_q.value  <= cell_key[0];
			rsp_q.last   <= dump_last;
		end else if (accept) begin
			rsp_q.value <= req.key;
			rsp_q.last  <= 1'b1;
			unique case (req.mode)
				MODE_INSERT: begin
					rsp_q.status <= found ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
				end
				MODE_REMOVE: begin
					rsp_q.status <= empty ? ST_EMPTY : (found ? ST_REMOVED : ST_NOTFOUND);
				end
				MODE_DUMP: begin
					rsp_q.status <= ST_EMPTY;
					rsp_q.value  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// control: occupancy, dump sequencing, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			cnt_q    <= '0;
			dump_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (dump_q) begin
				strobe_q <= 1'b1;
				cnt_q    <= cnt_q + IDX_W'(1);
				if (dump_last) begin
					dump_q <= 1'b0;
				end
			end else if (accept) begin
				unique case (req.mode)
					MODE_INSERT: begin
						strobe_q <= 1'b1;
						if (!found && !full) begin
							occ_q <= occ_q + OCC_W'(1);
						end
					end
					MODE_REMOVE: begin
						strobe_q <= 1'b1;
						if (found) begin
							occ_q <= occ_q - OCC_W'(1);
						end
					end
					MODE_DUMP: begin
						cnt_q <= '0;
						if (empty) begin
							strobe_q <= 1'b1;
						end else begin
							dump_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// checks
	`SUKL_ASSERT_NOW(a_occ_bound, occ_q <= OCC_W'(CAPACITY), "occupancy above capacity")
	`SUKL_ASSERT_NOW(a_sorted, !dump_q |-> (&order_ok), "chain out of order")
	`SUKL_ASSERT_NOW(a_dump_nonempty, dump_q |-> (occ_q != '0), "dump running on empty list")
	`SUKL_ASSERT_NEXT(a_one_result, single_op, strobe && rsp.last && !busy, "no final result")

endmodule

// ----- rtl/core/sukl_cell.sv -----
// One cell of the key chain: holds a key, compares it, shifts with its neighbors.
`timescale 1ns / 1ps

module sukl_cell
	import sukl_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic               valid,
	input  logic signed [31:0] prev_key,
	input  logic               prev_lt,
	input  logic signed [31:0] next_key,
	input  logic               next_valid,
	input  logic signed [31:0] head_key,
	output logic signed [31:0] key,
	output logic               lt,
	output logic               eq
);

	logic signed [31:0] key_q;

	// compare against the broadcast key
	assign key = key_q;
	assign lt  = valid && (key_q < ctl.key);
	assign eq  = valid && (key_q == ctl.key);

	// insert: first cell not below the key takes it, cells above shift up
	// remove: cells not below the key pull from above
	// rotate: valid prefix turns by one toward the head
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (!lt) begin
					key_q <= prev_lt ? ctl.key : prev_key;
				end
			end
			CELL_REMOVE: begin
				if (!lt) begin
					key_q <= next_key;
				end
			end
			CELL_ROTATE: begin
				key_q <= next_valid ? next_key : head_key;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- verif/key_list_check_pkg.sv -----
// Scoreboard class: ordered key list predictor and result checker.
`timescale 1ns / 1ps

package key_list_check_pkg;
	import sukl_pkg::*;

	class key_list_scoreboard;
		int   keys[CAPACITY];
		int   count;
		int   errors;
		rsp_t want_q[$];

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function void push_rsp(logic [2:0] status, int value, logic last);
			rsp_t r;
			r.status = status;
			r.value  = value;
			r.last   = last;
			want_q.push_back(r);
		endfunction

		// Update the list copy for one accepted word and queue the results it causes
		function void note_request(req_t w);
			int k;
			int pos;
			k   = w.key;
			pos = 0;
			// first slot not below the key
			while (pos < count && keys[pos] < k)
				pos++;
			case (w.mode)
				MODE_INSERT: begin
					if (pos < count && keys[pos] == k) begin
						push_rsp(ST_DUPLICATE, k, 1'b1);
					end else if (count >= CAPACITY) begin
						push_rsp(ST_FULL, k, 1'b1);
					end else begin
						for (int i = count; i > pos; i--)
							keys[i] = keys[i - 1];
						keys[pos] = k;
						count++;
						push_rsp(ST_INSERTED, k, 1'b1);
					end
				end
				MODE_REMOVE: begin
					if (count == 0) begin
						push_rsp(ST_EMPTY, k, 1'b1);
					end else if (pos >= count || keys[pos] != k) begin
						push_rsp(ST_NOTFOUND, k, 1'b1);
					end else begin
						for (int i = pos; i + 1 < count; i++)
							keys[i] = keys[i + 1];
						count--;
						push_rsp(ST_REMOVED, k, 1'b1);
					end
				end
				MODE_DUMP: begin
					if (count == 0) begin
						push_rsp(ST_EMPTY, 0, 1'b1);
					end else begin
						for (int i = 0; i < count; i++)
							push_rsp(ST_ENTRY, keys[i], (i + 1 == count));
					end
				end
				default: ;
			endcase
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		// Compare one result word with the oldest pending one
		function void check_result(rsp_t got);
			rsp_t want;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0d value %0d last %0d",
					$time, got.status, got.value, got.last);
				return;
			end
			want = want_q.pop_front();
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d actual %0d",
					$time, want.status, got.status);
			end
			if (got.value !== want.value) begin
				errors++;
				$display("%0t: value mismatch: expected %0d actual %0d",
					$time, want.value, got.value);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last mismatch: expected %0d actual %0d",
					$time, want.last, got.last);
			end
		endfunction
	endclass

endpackage

// ----- verif/tb_sorted_unique_key_list.sv -----
// Testbench top: directed and random traffic against the sorted unique key list.
`timescale 1ns / 1ps

module tb_sorted_unique_key_list;
	import sukl_pkg::*;
	import key_list_check_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_GAP      = 30;
	localparam int POOL_SIZE    = 24;
	localparam int PHASE_ITEMS  = 80;
	localparam int DRAIN_CYCLES = CAPACITY + 8;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic strobe;
	rsp_t rsp;

	key_list_scoreboard sb;
	int idle_pct;
	int idle_cycles;
	int key_pool[POOL_SIZE];

	sorted_unique_key_list u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.rsp    (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(rsp);
	end

	// watchdog: cycles with no request word accepted
	always @(posedge clk) begin
		if (start && !busy)
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Send one request word; called right after a rising edge
	task automatic send_word(input logic [1:0] mode, input int key);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			req   <= req_t'({$urandom, $urandom});
			@(posedge clk);
			gap++;
		end
		start <= 1'b1;
		req   <= '{mode: mode, key: key};
		do
			@(posedge clk);
		while (busy);
		sb.note_request(req);
	endtask

	// New key pool per phase so inserts and removes collide
	task automatic fill_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = $urandom_range(0, 15) - 8;
	endtask

	function automatic int pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 95)
			return $urandom;
		else if (r < 97)
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

	initial begin
		int ins_w[4];
		int pct[4];
		int r;
		logic [1:0] mode;

		ins_w = '{45, 40, 55, 38};
		pct   = '{0, 60, 0, 21};
		sb          = new();
		idle_pct    = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, unused mode, extremes, duplicate, absent key
		send_word(MODE_DUMP, 0);
		send_word(MODE_REMOVE, 32'sh8000_0000);
		send_word(2'd3, 1234);
		send_word(MODE_INSERT, 32'sh8000_0000);
		send_word(MODE_INSERT, 32'sh7fff_ffff);
		send_word(MODE_INSERT, 0);
		send_word(MODE_INSERT, -1);
		send_word(MODE_INSERT, 32'sh7fff_ffff);
		send_word(MODE_REMOVE, 5);
		send_word(MODE_REMOVE, -1);
		send_word(MODE_DUMP, 0);
		// fill to capacity, then full and duplicate-on-full
		for (int i = 0; i < CAPACITY - 3; i++)
			send_word(MODE_INSERT, i * 1000 + 37);
		send_word(MODE_INSERT, 99);
		send_word(MODE_INSERT, 0);
		send_word(MODE_DUMP, 0);

		// random phases with different sender idling
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = pct[ph];
			fill_pool();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < ins_w[ph])
					mode = MODE_INSERT;
				else if (r < ins_w[ph] + 30)
					mode = MODE_REMOVE;
				else if (r < 95)
					mode = MODE_DUMP;
				else
					mode = 2'd3;
				send_word(mode, pick_key());
			end
		end
		start <= 1'b0;

		// drain
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			if (sb.pending() != 0)
				$display("%0t: %0d results never arrived", $time, sb.pending());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
